// ===== rtl/snus_pkg.sv =====
package snus_pkg;

  // Fixed field widths of the request and result words.
  localparam int KEY_W     = 64;
  localparam int ENTRIES_W = 5;

  typedef logic [KEY_W-1:0] key_t;

  typedef struct packed {
    logic request_ok;
    key_t challenge_key;
  } in_word_t;

  typedef struct packed {
    logic                 accepted;
    logic                 already_seen;
    logic                 store_full;
    logic [ENTRIES_W-1:0] entries_used;
  } out_word_t;

  // Controls from the sequencer to the shared compare unit.
  typedef struct packed {
    logic clear;
    logic en;
  } cmp_ctrl_t;

endpackage

// ===== rtl/snus_ram.sv =====
module snus_ram #(
  parameter int WIDTH  = 64,
  parameter int DEPTH  = 16,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/snus_cmp.sv =====
module snus_cmp
  import snus_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  cmp_ctrl_t ctrl,
  input  key_t      key,
  input  key_t      slot_key,
  output logic      seen
);

  logic seen_r;
  logic seen_nxt;

  // Sticky match flag, one slot compared per enabled cycle.
  always_comb begin
    seen_nxt = seen_r;
    if (ctrl.clear) begin
      seen_nxt = 1'b0;
    end else if (ctrl.en && (slot_key == key)) begin
      seen_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r <= 1'b0;
    end else begin
      seen_r <= seen_nxt;
    end
  end

  assign seen = seen_r;

endmodule

// ===== rtl/single_use_nonce_store_core.sv =====
// Anti-replay store of single-use challenge keys.
// A request word on the in_ channel carries request_ok and challenge_key. The
// key, cut to its low KEY_BYTES bytes, is compared against every filled slot.
// If request_ok is set, the key is new and the store has room, the key is
// appended at the fill count and the count grows by one. A request with
// request_ok clear is a pure query and changes nothing.
// Each request gives exactly one result word on the out_ channel: accepted,
// already_seen, store_full and entries_used (the count after the request).
// Steps: the scan reads one slot a cycle from the single slot read port of the
// key memory into one shared comparator; a drain step then takes the last
// compare, and a decide step decides, appends and loads the result register,
// waiting there while the result register is still full. An empty store skips
// the scan and the drain. The result word is valid on the cycle after the
// decide step.
// in_ready is high only while no request is in work. The result register
// parts the two sides: a new request may be accepted while a result still
// waits, and a finished request holds in its decide step until the result
// register is free when the receiver stalls.
// Reset clears the fill count and the handshake state; the key memory needs
// no clearing, since slots at or above the count are never read.
module single_use_nonce_store_core
  import snus_pkg::*;
#(
  parameter int STORE_CAPACITY = 16,
  parameter int KEY_BYTES      = 8
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_word_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_data
);

  localparam int ADDR_W = (STORE_CAPACITY > 1) ? $clog2(STORE_CAPACITY) : 1;
  localparam int CNT_W  = $clog2(STORE_CAPACITY + 1);
  localparam key_t KEY_MASK = (KEY_BYTES >= 8) ? {KEY_W{1'b1}}
                                               : ((key_t'(1) << (8 * KEY_BYTES)) - key_t'(1));
  localparam logic [CNT_W-1:0] CAP = CNT_W'(STORE_CAPACITY);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_DONE
  } state_t;

  state_t            state_r;
  state_t            state_nxt;
  logic [CNT_W-1:0]  count_r;
  logic [CNT_W-1:0]  count_nxt;
  logic [ADDR_W-1:0] idx_r;
  logic [ADDR_W-1:0] idx_nxt;
  logic              cmp_vld_r;
  logic              cmp_vld_nxt;
  logic              ok_r;
  logic              ok_nxt;
  key_t              key_r;
  key_t              key_nxt;
  logic              out_valid_r;
  logic              out_valid_nxt;
  out_word_t         out_data_r;
  out_word_t         out_data_nxt;

  logic      in_fire;
  logic      full;
  logic      seen;
  logic      take;
  logic      done_go;
  logic      last_slot;
  cmp_ctrl_t cmp_ctrl;
  key_t      slot_key;

  assign in_ready  = (state_r == ST_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign full      = (count_r == CAP);
  assign take      = ok_r && !seen && !full;
  // The decide step waits until the result register is free.
  assign done_go   = !out_valid_r || out_ready;
  assign last_slot = ((CNT_W'(idx_r) + CNT_W'(1)) == count_r);

  // Key memory: one read port for the scan, one write port for the append.
  snus_ram #(
    .WIDTH (KEY_W),
    .DEPTH (STORE_CAPACITY)
  ) u_slots (
    .clk   (clk),
    .we    ((state_r == ST_DONE) && done_go && take),
    .waddr (ADDR_W'(count_r)),
    .wdata (key_r),
    .re    (state_r == ST_SCAN),
    .raddr (idx_r),
    .rdata (slot_key)
  );

  // The compare runs in the cycle after each slot read.
  assign cmp_ctrl.clear = in_fire;
  assign cmp_ctrl.en    = cmp_vld_r;

  snus_cmp u_cmp (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctrl     (cmp_ctrl),
    .key      (key_r),
    .slot_key (slot_key),
    .seen     (seen)
  );

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    idx_nxt       = idx_r;
    cmp_vld_nxt   = (state_r == ST_SCAN);
    ok_nxt        = ok_r;
    key_nxt       = key_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          ok_nxt  = in_data.request_ok;
          key_nxt = in_data.challenge_key & KEY_MASK;
          idx_nxt = '0;
          // An empty store has nothing to scan.
          state_nxt = (count_r == '0) ? ST_DONE : ST_SCAN;
        end
      end
      ST_SCAN: begin
        idx_nxt = idx_r + ADDR_W'(1);
        if (last_slot) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (done_go) begin
          if (take) begin
            count_nxt = count_r + CNT_W'(1);
          end
          out_valid_nxt             = 1'b1;
          out_data_nxt.accepted     = take;
          out_data_nxt.already_seen = seen;
          out_data_nxt.store_full   = full;
          out_data_nxt.entries_used = ENTRIES_W'(take ? (count_r + CNT_W'(1)) : count_r);
          state_nxt                 = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      cmp_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      cmp_vld_r   <= cmp_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
    idx_r      <= idx_nxt;
    ok_r       <= ok_nxt;
    key_r      <= key_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // The fill count saturates at capacity.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CAP)
    else $error("fill count above capacity");

  // A stored key was never seen and found room.
  a_accept_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.accepted) |-> (!out_data.already_seen && !out_data.store_full))
    else $error("key accepted while seen or full");

  // The count moves only through an append in the decide step.
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    !((state_r == ST_DONE) && done_go && take) |=> (count_r == $past(count_r)))
    else $error("fill count changed without an append");

  // A full store reports the capacity as its count.
  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.store_full) |-> (out_data.entries_used == ENTRIES_W'(CAP)))
    else $error("full store reports wrong count");

endmodule
